/* rtl/mmpd_pkg.sv */
// Shared types and constants of the multilevel min/max peak decimator.
// Holds the transaction payload structs, configuration layout and state entry formats.
// No dependencies.
`timescale 1ns / 1ps

package mmpd_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int CH_BITS        = 3;
	localparam int INDEX_BITS     = 32;
	localparam int RES_BITS       = 21;
	localparam int NCH_BITS       = 4;
	localparam int LVL_BITS       = 2;
	localparam int FACTOR_BITS    = 17;
	localparam int LEVEL_SLOTS    = 3;
	localparam int RESULT_SLOTS   = LEVEL_SLOTS + 1;
	localparam int SLOT_BITS      = $clog2(RESULT_SLOTS);
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = RES_BITS;

	localparam logic [RES_BITS-1:0]    BASE_RES_RESET      = RES_BITS'(1);
	localparam logic [NCH_BITS-1:0]    NUM_CHANNELS_RESET  = NCH_BITS'(1);
	localparam logic [LVL_BITS-1:0]    LEVELS_RESET        = LVL_BITS'(3);
	localparam logic [FACTOR_BITS-1:0] L1_FACTOR_RESET     = FACTOR_BITS'(16);
	localparam logic [FACTOR_BITS-1:0] L2_FACTOR_RESET     = FACTOR_BITS'(256);
	localparam logic [FACTOR_BITS-1:0] L3_FACTOR_RESET     = FACTOR_BITS'(4096);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BASE_RESOLUTION = 3'd0,
		REG_NUM_CHANNELS    = 3'd1,
		REG_LEVELS_IN_USE   = 3'd2,
		REG_LEVEL1_FACTOR   = 3'd3,
		REG_LEVEL2_FACTOR   = 3'd4,
		REG_LEVEL3_FACTOR   = 3'd5
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [CH_BITS-1:0] channel;
		sample_t            sample;
		logic               final_sample;
	} sample_item_t;

	typedef struct packed {
		logic [LVL_BITS-1:0]   level;
		logic [CH_BITS-1:0]    peak_channel;
		logic [INDEX_BITS-1:0] peak_index;
		sample_t               min_value;
		sample_t               max_value;
		logic                  last_of_run;
	} peak_item_t;

	typedef struct packed {
		logic [RES_BITS-1:0]                      base_res;
		logic [NCH_BITS-1:0]                      num_channels;
		logic [LVL_BITS-1:0]                      levels_in_use;
		logic [LEVEL_SLOTS-1:0][FACTOR_BITS-1:0]  factor;
	} cfg_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		sample_t               mn;
		sample_t               mx;
	} peak_t;

	typedef struct packed {
		sample_t               mn;
		sample_t               mx;
		logic [RES_BITS-1:0]   cnt;
		logic [INDEX_BITS-1:0] idx;
	} base_entry_t;

	typedef struct packed {
		sample_t                mn;
		sample_t                mx;
		logic [FACTOR_BITS-1:0] cnt;
		logic [INDEX_BITS-1:0]  idx;
	} agg_entry_t;

	typedef struct packed {
		logic [CH_BITS-1:0]                 ch;
		logic [RESULT_SLOTS-1:0]            mask;
		logic [RESULT_SLOTS-1:0]            lead;
		peak_t [RESULT_SLOTS-1:0]           slot;
	} bundle_t;

endpackage

/* rtl/mmpd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-channel state stores. No dependencies.
`timescale 1ns / 1ps

module mmpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/mmpd_base_upd.sv */
// Level-0 window update: folds one sample into a channel's base entry.
// Depends on mmpd_pkg.
`timescale 1ns / 1ps

module mmpd_base_upd (
	input  mmpd_pkg::cfg_t        cfg,
	input  mmpd_pkg::base_entry_t cur,
	input  mmpd_pkg::sample_t     sample,
	input  logic                  fin,
	output mmpd_pkg::base_entry_t nxt,
	output logic                  peak,
	output mmpd_pkg::peak_t       peak_data
);
	import mmpd_pkg::*;

	logic [RES_BITS-1:0] res_eff;
	logic [RES_BITS-1:0] cnt_inc;
	logic                first;
	logic                close;
	sample_t             mn;
	sample_t             mx;

	always_comb begin
		res_eff = (cfg.base_res == '0) ? RES_BITS'(1) : cfg.base_res;
		first   = (cur.cnt == '0);
		mn      = (first || ($signed(sample) < $signed(cur.mn))) ? sample : cur.mn;
		mx      = (first || ($signed(sample) > $signed(cur.mx))) ? sample : cur.mx;
		cnt_inc = cur.cnt + RES_BITS'(1);
		close   = (cnt_inc >= res_eff);
		// A final sample always leaves data in the window, so it always yields a peak.
		peak    = close || fin;

		peak_data.idx = cur.idx;
		peak_data.mn  = mn;
		peak_data.mx  = mx;

		nxt.mn = mn;
		nxt.mx = mx;
		priority if (fin) begin
			nxt.cnt = '0;
			nxt.idx = '0;
		end else if (close) begin
			nxt.cnt = '0;
			nxt.idx = cur.idx + INDEX_BITS'(1);
		end else begin
			nxt.cnt = cnt_inc;
			nxt.idx = cur.idx;
		end
	end

endmodule

/* rtl/mmpd_agg_upd.sv */
// Aggregated level update: folds a base peak into every enabled level of a channel.
// Depends on mmpd_pkg.
`timescale 1ns / 1ps

module mmpd_agg_upd #(
	parameter int NUM_AGG_LEVELS = 3,
	parameter int AGG_SLOTS      = (NUM_AGG_LEVELS > 0) ? NUM_AGG_LEVELS : 1
) (
	input  mmpd_pkg::cfg_t                                cfg,
	input  mmpd_pkg::agg_entry_t [AGG_SLOTS-1:0]          cur,
	input  logic                                          base_peak,
	input  logic                                          fin,
	input  mmpd_pkg::peak_t                               base_data,
	output mmpd_pkg::agg_entry_t [AGG_SLOTS-1:0]          nxt,
	output logic [mmpd_pkg::LEVEL_SLOTS-1:0]              emit,
	output logic [mmpd_pkg::LEVEL_SLOTS-1:0]              filled,
	output mmpd_pkg::peak_t [mmpd_pkg::LEVEL_SLOTS-1:0]   emit_data
);
	import mmpd_pkg::*;

	logic  [AGG_SLOTS-1:0] emit_s;
	logic  [AGG_SLOTS-1:0] full_s;
	peak_t [AGG_SLOTS-1:0] pk_s;

	for (genvar g = 0; g < AGG_SLOTS; g++) begin : g_level
		localparam logic [LVL_BITS-1:0] LVL = LVL_BITS'(g);

		logic                   en;
		logic                   feed;
		logic                   first;
		logic                   full;
		logic                   emit_l;
		logic [FACTOR_BITS-1:0] f_eff;
		logic [FACTOR_BITS-1:0] c_inc;
		sample_t                mn;
		sample_t                mx;
		peak_t                  pk_l;
		agg_entry_t             nxt_l;

		always_comb begin
			en     = (g < NUM_AGG_LEVELS) && (LVL < cfg.levels_in_use);
			f_eff  = (cfg.factor[g] == '0) ? FACTOR_BITS'(1) : cfg.factor[g];
			feed   = en && base_peak;
			first  = (cur[g].cnt == '0);
			mn     = (first || ($signed(base_data.mn) < $signed(cur[g].mn))) ?
			         base_data.mn : cur[g].mn;
			mx     = (first || ($signed(base_data.mx) > $signed(cur[g].mx))) ?
			         base_data.mx : cur[g].mx;
			c_inc  = cur[g].cnt + FACTOR_BITS'(1);
			full   = feed && (c_inc >= f_eff);
			// A fed level always holds data, so a final sample flushes it.
			emit_l = feed && (full || fin);

			pk_l.idx = cur[g].idx;
			pk_l.mn  = mn;
			pk_l.mx  = mx;

			// A final sample clears every level, enabled or not.
			priority if (fin) begin
				nxt_l.mn  = mn;
				nxt_l.mx  = mx;
				nxt_l.cnt = '0;
				nxt_l.idx = '0;
			end else if (full) begin
				nxt_l.mn  = mn;
				nxt_l.mx  = mx;
				nxt_l.cnt = '0;
				nxt_l.idx = cur[g].idx + INDEX_BITS'(1);
			end else if (feed) begin
				nxt_l.mn  = mn;
				nxt_l.mx  = mx;
				nxt_l.cnt = c_inc;
				nxt_l.idx = cur[g].idx;
			end else begin
				nxt_l = cur[g];
			end
		end

		assign nxt[g]    = nxt_l;
		assign emit_s[g] = emit_l;
		assign full_s[g] = full;
		assign pk_s[g]   = pk_l;
	end

	for (genvar g = 0; g < LEVEL_SLOTS; g++) begin : g_out
		if (g < NUM_AGG_LEVELS) begin : g_used
			assign emit[g]      = emit_s[g];
			assign filled[g]    = full_s[g];
			assign emit_data[g] = pk_s[g];
		end else begin : g_unused
			assign emit[g]      = 1'b0;
			assign filled[g]    = 1'b0;
			assign emit_data[g] = '0;
		end
	end

endmodule

/* rtl/mmpd_result_queue.sv */
// Result queue: holds per-sample result bundles and hands out one peak per transaction.
// Depends on mmpd_pkg.
`timescale 1ns / 1ps

module mmpd_result_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  mmpd_pkg::bundle_t                    push_data,
	output logic [mmpd_pkg::QUEUE_CNT_BITS-1:0]  used,
	output logic                                 peak_valid,
	input  logic                                 peak_stall,
	output mmpd_pkg::peak_item_t                 peak_item
);
	import mmpd_pkg::*;

	bundle_t                   store_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] head_q;
	logic [QUEUE_PTR_BITS-1:0] tail_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;

	bundle_t                 head;
	logic [SLOT_BITS-1:0]    sel;
	logic [RESULT_SLOTS-1:0] remaining;
	logic                    last;
	logic                    take;
	logic                    pop;

	always_comb begin
		head = store_q[head_q];
		sel  = '0;
		for (int i = RESULT_SLOTS - 1; i >= 0; i--) begin
			if (head.mask[i]) begin
				sel = SLOT_BITS'(i);
			end
		end
		// Levels that fill on the sample's base peak go out ahead of the levels that a
		// final sample only flushes. The base peak is always among the former.
		for (int i = RESULT_SLOTS - 1; i >= 0; i--) begin
			if (head.mask[i] && head.lead[i]) begin
				sel = SLOT_BITS'(i);
			end
		end
		remaining = head.mask & ~(RESULT_SLOTS'(1) << sel);
		last      = (remaining == '0);
		take      = peak_valid && !peak_stall;
		pop       = take && last;

		peak_item.level        = LVL_BITS'(sel);
		peak_item.peak_channel = head.ch;
		peak_item.peak_index   = head.slot[sel].idx;
		peak_item.min_value    = head.slot[sel].mn;
		peak_item.max_value    = head.slot[sel].mx;
		peak_item.last_of_run  = last;
	end

	assign peak_valid = (count_q != '0);
	assign used       = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[tail_q] <= push_data;
		end
		if (take && !last) begin
			store_q[head_q].mask <= remaining;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				head_q <= head_q + QUEUE_PTR_BITS'(1);
			end
			count_q <= count_q + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
		end
	end

endmodule

/* rtl/multilevel_minmax_peak_decimator_unit.sv */
// Multilevel min/max peak decimator, top level; uses mmpd_pkg, mmpd_ram and the update units.
// The first peak of a sample is offered by the result queue after stage 2 pushes its bundle.
// Throughput: one sample per cycle while sample_stall is low; a sample causing k peaks takes
// k peak port transactions. A 4-bundle result queue is shared with the 2 stages in flight.
// Reset (arst_n, async, active low) loads register defaults and clears per-channel valid bits.
`timescale 1ns / 1ps

module multilevel_minmax_peak_decimator_unit #(
	parameter int MAX_CHANNELS   = 8,
	parameter int NUM_AGG_LEVELS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  mmpd_pkg::sample_item_t               sample_item,
	output logic                                 peak_valid,
	input  logic                                 peak_stall,
	output mmpd_pkg::peak_item_t                 peak_item,
	input  logic                                 cfg_write,
	input  logic [mmpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [mmpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import mmpd_pkg::*;

	// Per-channel state lives in two RAMs addressed by channel. The base store is read
	// when a sample transaction is taken and written back at the end of stage 1. The
	// aggregated store is read as the sample leaves stage 1 and written back at the end
	// of stage 2. In both cases the only overlap is with the sample exactly one ahead,
	// whose write lands on the same edge as the read, so one forwarding path per store
	// is enough.
	localparam int CH_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int AGG_SLOTS = (NUM_AGG_LEVELS > 0) ? NUM_AGG_LEVELS : 1;
	localparam int BASE_W    = $bits(base_entry_t);
	localparam int AGG_W     = AGG_SLOTS * $bits(agg_entry_t);
	localparam int OCC_BITS  = QUEUE_CNT_BITS + 1;

	// Configuration registers.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_res      <= BASE_RES_RESET;
			cfg_q.num_channels  <= NUM_CHANNELS_RESET;
			cfg_q.levels_in_use <= LEVELS_RESET;
			cfg_q.factor[0]     <= L1_FACTOR_RESET;
			cfg_q.factor[1]     <= L2_FACTOR_RESET;
			cfg_q.factor[2]     <= L3_FACTOR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_RESOLUTION: cfg_q.base_res      <= cfg_data[RES_BITS-1:0];
				REG_NUM_CHANNELS:    cfg_q.num_channels  <= cfg_data[NCH_BITS-1:0];
				REG_LEVELS_IN_USE:   cfg_q.levels_in_use <= cfg_data[LVL_BITS-1:0];
				REG_LEVEL1_FACTOR:   cfg_q.factor[0]     <= cfg_data[FACTOR_BITS-1:0];
				REG_LEVEL2_FACTOR:   cfg_q.factor[1]     <= cfg_data[FACTOR_BITS-1:0];
				REG_LEVEL3_FACTOR:   cfg_q.factor[2]     <= cfg_data[FACTOR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline registers.
	logic               v_s1;
	logic [CH_AW-1:0]   addr_s1;
	logic [CH_BITS-1:0] ch_s1;
	sample_t            sample_s1;
	logic               fin_s1;

	logic               v_s2;
	logic [CH_AW-1:0]   addr_s2;
	logic [CH_BITS-1:0] ch_s2;
	logic               fin_s2;
	logic               bpeak_s2;
	peak_t              bpk_s2;
	base_entry_t        bnext_s2;

	logic                          v_s3;
	logic [CH_AW-1:0]              addr_s3;
	agg_entry_t [AGG_SLOTS-1:0]    anext_s3;

	// Input side. A sample on a channel that is not in use is taken and dropped:
	// it never enters the pipeline.
	logic [QUEUE_CNT_BITS-1:0]     q_used;
	logic                          accept;
	logic                          in_range;
	logic [CH_AW+CH_BITS-1:0]      ch_wide;
	logic [CH_AW-1:0]              in_addr;

	// Every sample in flight reserves a queue slot, so stage 2 never has to wait.
	assign sample_stall = (OCC_BITS'(q_used) + OCC_BITS'(v_s1) + OCC_BITS'(v_s2))
	                      >= OCC_BITS'(QUEUE_DEPTH);
	assign accept       = sample_valid && !sample_stall;
	assign in_range     = ({1'b0, sample_item.channel} < cfg_q.num_channels) &&
	                      (int'(sample_item.channel) < MAX_CHANNELS);
	assign ch_wide      = (CH_AW + CH_BITS)'(sample_item.channel);
	assign in_addr      = ch_wide[CH_AW-1:0];

	// Row valid bits: a channel never written reads as counts and indices of zero.
	logic [MAX_CHANNELS-1:0] bv_q;
	logic [MAX_CHANNELS-1:0] av_q;

	// Stage 1: base window update.
	logic [BASE_W-1:0] rd_b;
	base_entry_t       cur_b;
	base_entry_t       bnext;
	logic              bpeak;
	peak_t             bpk;

	mmpd_ram #(
		.WIDTH (BASE_W),
		.DEPTH (MAX_CHANNELS),
		.AW    (CH_AW)
	) u_base_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (bnext),
		.raddr (in_addr),
		.rdata (rd_b)
	);

	always_comb begin
		priority if (v_s2 && (addr_s2 == addr_s1)) begin
			cur_b = bnext_s2;
		end else if (bv_q[addr_s1]) begin
			cur_b = base_entry_t'(rd_b);
		end else begin
			cur_b = '0;
		end
	end

	mmpd_base_upd u_base_upd (
		.cfg       (cfg_q),
		.cur       (cur_b),
		.sample    (sample_s1),
		.fin       (fin_s1),
		.nxt       (bnext),
		.peak      (bpeak),
		.peak_data (bpk)
	);

	// Stage 2: aggregated level update and result bundle.
	logic [AGG_W-1:0]             rd_a;
	agg_entry_t [AGG_SLOTS-1:0]   cur_a;
	agg_entry_t [AGG_SLOTS-1:0]   anext;
	logic [LEVEL_SLOTS-1:0]       emit;
	logic [LEVEL_SLOTS-1:0]       filled;
	peak_t [LEVEL_SLOTS-1:0]      emit_data;
	bundle_t                      bundle;
	logic                         push;

	mmpd_ram #(
		.WIDTH (AGG_W),
		.DEPTH (MAX_CHANNELS),
		.AW    (CH_AW)
	) u_agg_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (addr_s2),
		.wdata (anext),
		.raddr (addr_s1),
		.rdata (rd_a)
	);

	always_comb begin
		priority if (v_s3 && (addr_s3 == addr_s2)) begin
			cur_a = anext_s3;
		end else if (av_q[addr_s2]) begin
			cur_a = rd_a;
		end else begin
			cur_a = '0;
		end
	end

	mmpd_agg_upd #(
		.NUM_AGG_LEVELS (NUM_AGG_LEVELS),
		.AGG_SLOTS      (AGG_SLOTS)
	) u_agg_upd (
		.cfg       (cfg_q),
		.cur       (cur_a),
		.base_peak (bpeak_s2),
		.fin       (fin_s2),
		.base_data (bpk_s2),
		.nxt       (anext),
		.emit      (emit),
		.filled    (filled),
		.emit_data (emit_data)
	);

	// The base peak is always first in a bundle. Levels that fill on this base peak follow
	// in ascending order, then the levels that a final sample flushes, also ascending.
	always_comb begin
		bundle.ch   = ch_s2;
		bundle.mask = {emit, 1'b1};
		bundle.lead = {filled, 1'b1};
		bundle.slot = {emit_data, bpk_s2};
	end

	assign push = v_s2 && bpeak_s2;

	mmpd_result_queue u_result_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (bundle),
		.used       (q_used),
		.peak_valid (peak_valid),
		.peak_stall (peak_stall),
		.peak_item  (peak_item)
	);

	// Control state of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			bv_q <= '0;
			av_q <= '0;
		end else begin
			v_s1 <= accept && in_range;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				bv_q[addr_s1] <= 1'b1;
			end
			if (v_s2) begin
				av_q[addr_s2] <= 1'b1;
			end
		end
	end

	// Payload of the pipeline. The stages never hold, so they load every cycle.
	always_ff @(posedge clk) begin
		addr_s1   <= in_addr;
		ch_s1     <= sample_item.channel;
		sample_s1 <= sample_item.sample;
		fin_s1    <= sample_item.final_sample;

		addr_s2   <= addr_s1;
		ch_s2     <= ch_s1;
		fin_s2    <= fin_s1;
		bpeak_s2  <= bpeak;
		bpk_s2    <= bpk;
		bnext_s2  <= bnext;

		addr_s3   <= addr_s2;
		anext_s3  <= anext;
	end

endmodule
